>>> rtl/cwdl_pkg.sv
// Shared types and constants for the CAN wrench decoder with low-pass filters.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package cwdl_pkg;

    localparam int NUM_AXES    = 6;
    localparam int NUM_WORDS   = 3;
    localparam int ID_W        = 11;
    localparam int WORD_W      = 16;
    localparam int DEC_W       = 17;
    localparam int FILT_W      = 33;
    localparam int ALPHA_W     = 16;
    localparam int FRAC_BITS   = 16;
    localparam int AX_W        = 33;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 304;

    localparam logic [ID_W-1:0] ID_FORCE  = 11'd1;
    localparam logic [ID_W-1:0] ID_TORQUE = 11'd2;

    localparam logic [DEC_W-1:0]   FORCE_OFFSET  = 17'd30000;
    localparam logic [DEC_W-1:0]   TORQUE_OFFSET = 17'd25000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 16'd3874;

    typedef logic signed [DEC_W-1:0]  dec_t;
    typedef logic signed [FILT_W-1:0] filt_t;

    // Per-lane control: load takes a new decoded value, take starts a filter
    // step for an accepted frame, step retires it into the filter state.
    typedef struct packed {
        logic load;
        logic take;
        logic step;
    } lane_ctl_t;

endpackage

`default_nettype wire

>>> rtl/cwdl_lane.sv
// One axis lane: decoded value register, alpha*x product and the filter state.
// Depends on cwdl_pkg.
`default_nettype none

module cwdl_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cwdl_pkg::lane_ctl_t           ctl,
    input  wire logic [cwdl_pkg::WORD_W-1:0]   word,
    input  wire logic [cwdl_pkg::DEC_W-1:0]    offset,
    input  wire logic [cwdl_pkg::ALPHA_W-1:0]  alpha,
    output cwdl_pkg::dec_t                     dec,
    output cwdl_pkg::filt_t                    filt_next
);

    cwdl_pkg::dec_t                        dec_reg;
    cwdl_pkg::dec_t                        dec_next;
    logic signed [cwdl_pkg::AX_W-1:0]      ax_reg;
    logic signed [2*cwdl_pkg::DEC_W-1:0]   ax_full;
    logic signed [cwdl_pkg::DEC_W-1:0]     alpha_s;
    cwdl_pkg::filt_t                       filt_reg;
    logic signed [cwdl_pkg::FILT_W+cwdl_pkg::DEC_W-1:0] prod;
    logic signed [50:0]                    diff;
    logic signed [34:0]                    sum;

    assign alpha_s = signed'({1'b0, alpha});

    // Select the new decoded value: raw word minus the group offset
    assign dec_next = ctl.load ? cwdl_pkg::dec_t'({1'b0, word} - offset) : dec_reg;

    // alpha * x, exact; the magnitude stays within 33 signed bits
    assign ax_full = dec_next * alpha_s;

    // Filter step: f + floor((alpha*x*2^16 - alpha*f) / 2^16)
    assign prod      = filt_reg * alpha_s;
    assign diff      = {{2{ax_reg[cwdl_pkg::AX_W-1]}}, ax_reg, {cwdl_pkg::FRAC_BITS{1'b0}}}
                       - {prod[49], prod};
    assign sum       = {{2{filt_reg[cwdl_pkg::FILT_W-1]}}, filt_reg} + diff[50:16];
    assign filt_next = sum[cwdl_pkg::FILT_W-1:0];
    assign dec       = dec_reg;

    // Hold decoded and filter state between frames
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg  <= '0;
            filt_reg <= '0;
        end
        else
        begin
            if (ctl.take)
            begin
                dec_reg <= dec_next;
            end
            if (ctl.step)
            begin
                filt_reg <= filt_next;
            end
        end
    end

    // Capture alpha*x for the following filter step
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            ax_reg <= ax_full[cwdl_pkg::AX_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> rtl/cwdl_merge.sv
// Merging stage: gathers the six lanes into one result and holds it in the
// output register until the sink takes it. Depends on cwdl_pkg.
`default_nettype none

module cwdl_merge (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step,
    input  wire cwdl_pkg::dec_t                    dec    [cwdl_pkg::NUM_AXES],
    input  wire cwdl_pkg::filt_t                   filt   [cwdl_pkg::NUM_AXES],
    output logic                                   adv,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [cwdl_pkg::OUT_DATA_W-1:0]        out_data
);

    logic                               valid_reg;
    logic                               valid_next;
    logic [cwdl_pkg::OUT_DATA_W-1:0]    data_reg;
    logic [cwdl_pkg::OUT_DATA_W-1:0]    data_next;

    // Output register is free when empty or being drained this cycle
    assign adv = !valid_reg || out_ready;

    // Pack decoded values first, then filtered values, zero pad on top
    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < cwdl_pkg::NUM_AXES; i++)
        begin
            data_next[i*cwdl_pkg::DEC_W +: cwdl_pkg::DEC_W] = dec[i];
            data_next[cwdl_pkg::NUM_AXES*cwdl_pkg::DEC_W + i*cwdl_pkg::FILT_W
                      +: cwdl_pkg::FILT_W] = filt[i];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result transaction
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/can_wrench_decode_lowpass.sv
// Top level: CAN force/torque frame decode, six parallel low-pass lanes and
// the merging output stage. Depends on cwdl_pkg, cwdl_lane, cwdl_merge.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  can_id (tuser), data_length, word_x/y/z
//  m_axis    out  m_axis_tvalid/m_axis_tready  six decoded, six filtered values
//  cfg       in   cfg_wr_en                    smoothing_factor (alpha, Q0.16)
//
// One frame per cycle sustained while the sink is ready. Two register stages per
// lane (decode + alpha*x, then the filter multiply-add into the output register):
// m_axis_tvalid rises when the frame moves from the decode stage into the output
// register, which waits while the output register is full and the sink is stalled.
// The per-lane loop f -> alpha*f -> f through the filter state bounds the cycle.
// Frames that are short or carry another id are accepted and dropped.
// Reset clears decoded and filter state and sets alpha to 3874.
// A stalled sink holds the output register; input stalls only when the decode
// stage and the output register are both full and the sink is not ready.
`default_nettype none

module can_wrench_decode_lowpass (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // can_id[10:0]
    input  wire logic [cwdl_pkg::ID_W-1:0]           s_axis_tuser,
    // data_length[3:0], word_x[19:4], word_y[35:20], word_z[51:36], zero [55:52]
    input  wire logic [cwdl_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // force_x/y/z, torque_x/y/z (17 bits each) [101:0],
    // smooth_force_x/y/z, smooth_torque_x/y/z (33 bits each) [299:102], zero [303:300]
    output logic [cwdl_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [cwdl_pkg::ALPHA_W-1:0]        cfg_wr_data
);

    logic [cwdl_pkg::ALPHA_W-1:0]  alpha_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          in_acc;
    logic                          frame_ok;
    logic                          is_force;
    logic                          is_torque;
    logic                          take;
    logic                          step;
    logic                          adv;
    logic [cwdl_pkg::ID_W-1:0]     can_id;
    logic [3:0]                    data_length;
    logic [cwdl_pkg::WORD_W-1:0]   words [cwdl_pkg::NUM_WORDS];
    cwdl_pkg::lane_ctl_t           lane_ctl  [cwdl_pkg::NUM_AXES];
    cwdl_pkg::dec_t                lane_dec  [cwdl_pkg::NUM_AXES];
    cwdl_pkg::filt_t               lane_filt [cwdl_pkg::NUM_AXES];

    // Unpack the input transaction
    assign can_id      = s_axis_tuser;
    assign data_length = s_axis_tdata[3:0];
    assign words[0]    = s_axis_tdata[19:4];
    assign words[1]    = s_axis_tdata[35:20];
    assign words[2]    = s_axis_tdata[51:36];

    // Classify the frame: at least 8 bytes and a known id
    assign is_force  = data_length[3] && (can_id == cwdl_pkg::ID_FORCE);
    assign is_torque = data_length[3] && (can_id == cwdl_pkg::ID_TORQUE);
    assign frame_ok  = is_force || is_torque;

    assign s_axis_tready = !s1_valid_reg || adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign take          = in_acc && frame_ok;
    assign step          = s1_valid_reg && adv;

    // Advance the decode stage valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = frame_ok;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            alpha_reg    <= cwdl_pkg::ALPHA_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_wr_en)
            begin
                alpha_reg <= cfg_wr_data;
            end
        end
    end

    // Six filter lanes: force x/y/z then torque x/y/z
    for (genvar g = 0; g < cwdl_pkg::NUM_AXES; g++)
    begin : g_lane
        localparam bit IS_FORCE_LANE = (g < cwdl_pkg::NUM_WORDS);

        assign lane_ctl[g].load = take && (IS_FORCE_LANE ? is_force : is_torque);
        assign lane_ctl[g].take = take;
        assign lane_ctl[g].step = step;

        cwdl_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (lane_ctl[g]),
            .word      (words[g % cwdl_pkg::NUM_WORDS]),
            .offset    (IS_FORCE_LANE ? cwdl_pkg::FORCE_OFFSET : cwdl_pkg::TORQUE_OFFSET),
            .alpha     (alpha_reg),
            .dec       (lane_dec[g]),
            .filt_next (lane_filt[g])
        );
    end

    cwdl_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .dec       (lane_dec),
        .filt      (lane_filt),
        .adv       (adv),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // A full decode stage behind a stalled output blocks new frames
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline is full and stalled");

    // An accepted frame occupies the decode stage only when it is valid
    a_drop_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (s1_valid_reg == $past(frame_ok)))
        else $error("decode stage valid does not follow frame check");

    // A result only appears after a frame sat in the decode stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_valid_reg))
        else $error("result without a decoded frame");

endmodule

`default_nettype wire

>>> verif/can_wrench_decode_lowpass_tb.sv
// Testbench for can_wrench_decode_lowpass: CAN force/torque frames in, decoded and
// low-pass filtered axes out, checked against an in-bench predictor of the six filters.
// Depends on rtl/cwdl_pkg.sv and rtl/can_wrench_decode_lowpass.sv.
`timescale 1ns / 100ps

module can_wrench_decode_lowpass_tb;

    localparam int NUM_FIELDS   = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE_TICKS = 6;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [cwdl_pkg::ID_W-1:0]       s_axis_tuser = '0;
    logic [cwdl_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [cwdl_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            cfg_wr_en = 1'b0;
    logic [cwdl_pkg::ALPHA_W-1:0]    cfg_wr_data = '0;

    // Predictor state: decoded axes, filter accumulators and alpha
    cwdl_pkg::dec_t               axis_raw[cwdl_pkg::NUM_AXES];
    cwdl_pkg::filt_t              axis_smooth[cwdl_pkg::NUM_AXES];
    logic [cwdl_pkg::ALPHA_W-1:0] model_alpha = cwdl_pkg::ALPHA_RESET;

    // Expected wrench readings, oldest first
    logic [cwdl_pkg::OUT_DATA_W-1:0] pending_readings[$];

    int   fail_count = 0;
    int   idle_cycles = 0;
    bit   src_gaps = 1'b0;
    bit   sink_stalls = 1'b0;
    int   stall_left = 0;

    string field_names[NUM_FIELDS] = '{
        "force_x", "force_y", "force_z", "torque_x", "torque_y", "torque_z",
        "smooth_force_x", "smooth_force_y", "smooth_force_z",
        "smooth_torque_x", "smooth_torque_y", "smooth_torque_z"
    };

    can_wrench_decode_lowpass dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Extract one output field, sign-extended
    function automatic longint field_value(input logic [cwdl_pkg::OUT_DATA_W-1:0] vec,
                                           input int idx);
        logic [cwdl_pkg::FILT_W-1:0] raw;
        if (idx < cwdl_pkg::NUM_AXES)
        begin
            raw = vec[cwdl_pkg::DEC_W*idx +: cwdl_pkg::FILT_W];
            return longint'(cwdl_pkg::dec_t'(raw[cwdl_pkg::DEC_W-1:0]));
        end
        raw = vec[cwdl_pkg::DEC_W*cwdl_pkg::NUM_AXES
                  + cwdl_pkg::FILT_W*(idx-cwdl_pkg::NUM_AXES) +: cwdl_pkg::FILT_W];
        return longint'(cwdl_pkg::filt_t'(raw));
    endfunction

    // Decode a well-formed frame, step all six filters and queue the reading it yields
    task automatic predict_frame(input logic [cwdl_pkg::ID_W-1:0] id, input logic [3:0] len,
                                 input logic [15:0] wx, input logic [15:0] wy,
                                 input logic [15:0] wz);
        logic [15:0]                     words[3];
        logic [cwdl_pkg::DEC_W-1:0]      offset;
        int                              base;
        longint                          diff;
        longint                          prod;
        logic [cwdl_pkg::OUT_DATA_W-1:0] reading;
        words[0] = wx;
        words[1] = wy;
        words[2] = wz;
        if (len >= 4'd8 && (id == cwdl_pkg::ID_FORCE || id == cwdl_pkg::ID_TORQUE))
        begin
            base   = (id == cwdl_pkg::ID_FORCE) ? 0 : 3;
            offset = (id == cwdl_pkg::ID_FORCE) ? cwdl_pkg::FORCE_OFFSET
                                                : cwdl_pkg::TORQUE_OFFSET;
            for (int i = 0; i < 3; i++)
                axis_raw[base+i] = cwdl_pkg::dec_t'({1'b0, words[i]} - offset);
            reading = '0;
            for (int a = 0; a < cwdl_pkg::NUM_AXES; a++)
            begin
                diff = longint'(axis_raw[a]) * 65536 - longint'(axis_smooth[a]);
                prod = longint'(model_alpha) * diff;
                axis_smooth[a] = cwdl_pkg::filt_t'(longint'(axis_smooth[a])
                                                   + (prod >>> cwdl_pkg::FRAC_BITS));
                reading[cwdl_pkg::DEC_W*a +: cwdl_pkg::DEC_W] = axis_raw[a];
                reading[cwdl_pkg::DEC_W*cwdl_pkg::NUM_AXES + cwdl_pkg::FILT_W*a
                        +: cwdl_pkg::FILT_W] = axis_smooth[a];
            end
            pending_readings.push_back(reading);
        end
    endtask

    // Present one frame and hold it until the transaction completes
    task automatic send_frame(input logic [cwdl_pkg::ID_W-1:0] id, input logic [3:0] len,
                              input logic [15:0] wx, input logic [15:0] wy,
                              input logic [15:0] wz);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_axis_tuser  = id;
        s_axis_tdata  = {4'b0000, wz, wy, wx, len};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_frame(id, len, wx, wy, wz);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait for all readings, then let dropped frames clear the pipeline
    task automatic settle_idle();
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_alpha(input logic [cwdl_pkg::ALPHA_W-1:0] value);
        settle_idle();
        cfg_wr_data = value;
        cfg_wr_en   = 1'b1;
        @(posedge clk);
        model_alpha = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [15:0] random_word();
        unique case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly well-formed frames, some short frames and bus noise
    task automatic send_random_frame();
        logic [cwdl_pkg::ID_W-1:0] id;
        logic [3:0]                len;
        int                        pick;
        pick = $urandom_range(0, 9);
        id   = ($urandom_range(0, 1) == 0) ? cwdl_pkg::ID_FORCE : cwdl_pkg::ID_TORQUE;
        if (pick == 0)
        begin
            id  = 11'($urandom_range(0, 2047));
            len = 4'($urandom_range(0, 15));
        end
        else if (pick == 1)
            len = 4'($urandom_range(0, 7));
        else if (pick == 2)
            len = 4'($urandom_range(9, 15));
        else
            len = 4'd8;
        send_frame(id, len, random_word(), random_word(), random_word());
    endtask

    // Field extremes, both frame kinds, short frames, long lengths, foreign ids
    task automatic test_directed();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_frame(cwdl_pkg::ID_FORCE,  4'd8,  16'h0000, 16'h0000, 16'h0000);
        send_frame(cwdl_pkg::ID_TORQUE, 4'd8,  16'h0000, 16'h0000, 16'h0000);
        send_frame(cwdl_pkg::ID_FORCE,  4'd8,  16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(cwdl_pkg::ID_TORQUE, 4'd8,  16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(cwdl_pkg::ID_FORCE,  4'd15, 16'd30000, 16'd30000, 16'd30000);
        send_frame(cwdl_pkg::ID_TORQUE, 4'd9,  16'd25000, 16'd25000, 16'd25000);
        send_frame(cwdl_pkg::ID_FORCE,  4'd7,  16'h1234, 16'h5678, 16'h9ABC);
        send_frame(cwdl_pkg::ID_TORQUE, 4'd0,  16'h1234, 16'h5678, 16'h9ABC);
        send_frame(11'd0,               4'd8,  16'hFFFF, 16'h0000, 16'hFFFF);
        send_frame(11'd3,               4'd8,  16'h0000, 16'hFFFF, 16'h0000);
        send_frame(11'd2047,            4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(11'd1025,            4'd8,  16'h0001, 16'h0002, 16'h0003);
        send_frame(11'd1026,            4'd8,  16'h0004, 16'h0005, 16'h0006);
        send_frame(cwdl_pkg::ID_FORCE,  4'd8,  16'hAAAA, 16'h5555, 16'hAAAA);
        send_frame(cwdl_pkg::ID_TORQUE, 4'd8,  16'h5555, 16'hAAAA, 16'h5555);
        send_frame(cwdl_pkg::ID_FORCE,  4'd8,  16'h0000, 16'hFFFF, 16'h0000);
        send_frame(cwdl_pkg::ID_TORQUE, 4'd12, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_frame(cwdl_pkg::ID_FORCE,  4'd15, 16'hFFFF, 16'h0000, 16'h8000);
    endtask

    // Alpha extremes: zero holds the filters, full scale tracks the input
    task automatic test_alpha_extremes();
        logic [cwdl_pkg::ALPHA_W-1:0] settings[4] = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFE};
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        foreach (settings[s])
        begin
            write_alpha(settings[s]);
            repeat (30) send_random_frame();
        end
    endtask

    // Random alpha per phase, with gaps and stalls switched on and off
    task automatic test_random_phases();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_alpha(16'($urandom_range(0, 65535)));
            for (int n = 0; n < 280; n++)
            begin
                if (n % 40 == 0)
                begin
                    src_gaps    = ($urandom_range(0, 3) != 0);
                    sink_stalls = ($urandom_range(0, 3) != 0);
                end
                send_random_frame();
            end
        end
    endtask

    // Back-to-back frames with the sink always ready
    task automatic test_full_rate();
        write_alpha(16'($urandom_range(0, 65535)));
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        repeat (150) send_random_frame();
    endtask

    // Sink ready: stall in random bursts when enabled
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready = 1'b0;
        end
        else if (sink_stalls && $urandom_range(0, 4) == 0)
        begin
            stall_left    = $urandom_range(0, 6);
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = 1'b1;
    end

    // Compare each output transaction with the oldest expected reading
    always @(posedge clk)
    begin
        logic [cwdl_pkg::OUT_DATA_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading: %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                for (int f = 0; f < NUM_FIELDS; f++)
                begin
                    if (field_value(want, f) != field_value(m_axis_tdata, f))
                    begin
                        $error("%s: expected %0d, actual %0d", field_names[f],
                               field_value(want, f), field_value(m_axis_tdata, f));
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run if no transaction happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        for (int a = 0; a < cwdl_pkg::NUM_AXES; a++)
        begin
            axis_raw[a]    = '0;
            axis_smooth[a] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_alpha_extremes();
        test_random_phases();
        test_full_rate();
        settle_idle();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
